// ----- hdl/cdq_pkg.sv -----
// Shared types and codes of the circular deque controller.
package cdq_pkg;

   // Action codes of an input item.
   typedef logic [1:0] action_type;
   localparam action_type ACT_PUSH_BACK  = 2'd0;
   localparam action_type ACT_PUSH_FRONT = 2'd1;
   localparam action_type ACT_POP_BACK   = 2'd2;
   localparam action_type ACT_POP_FRONT  = 2'd3;

   // Status codes of a result item.
   typedef logic [1:0] status_type;
   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_OVERFLOW  = 2'd1;
   localparam status_type ST_UNDERFLOW = 2'd2;

   // Fixed field widths.
   localparam int WORD_W = 32;
   localparam int OCC_W  = 4;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [OCC_W-1:0]         occ_type;

endpackage

// ----- hdl/circular_deque_controller_core.sv -----
// Top level of the circular deque controller: indices, count and result stage.
//
// A fixed-capacity double-ended queue of signed 32-bit words held in a ring RAM.
// Input channel: an item is taken at a rising edge where start is high and busy
// is low; req_action selects push back, push front, pop back or pop front, and
// req_push_value is the word stored by a push.
// Result channel: exactly one result per item, shown for one cycle with
// rsp_strobe high, in the cycle right after the item was taken. It carries a
// status (ok, overflow, underflow), the popped word (zero otherwise) and the
// occupancy after the step.
// The ring RAM has a registered read port, so a popped word appears in the
// cycle after the pop is taken. Indices and count update at the accepting
// edge, so busy stays low and a new item can be taken every cycle; one item
// per cycle is the sustained rate.
// A push writes the RAM at the accepting edge; a pop reads it at that edge. A
// write is visible to a read issued in the next cycle; no forwarding is needed.
// Reset (synchronous, active high) empties the deque and clears both indices;
// RAM contents are left as they are and are never read before being written.
// The receiver cannot stall: each result must be taken in its strobe cycle.
module circular_deque_controller_core #(
   parameter int CAPACITY = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  cdq_pkg::action_type  req_action,
   input  cdq_pkg::word_type    req_push_value,
   output logic                 rsp_strobe,
   output cdq_pkg::status_type  rsp_status,
   output cdq_pkg::word_type    rsp_removed_value,
   output cdq_pkg::occ_type     rsp_occupancy
);
   import cdq_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             strobe_ff;
   status_type       status_ff, status_in;
   logic             pop_ok_ff, pop_ok_in;

   logic             accept;
   logic             is_push;
   logic             full;
   logic             empty;
   logic [IDX_W-1:0] head_next, head_prev, tail_next, tail_prev;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [WORD_W-1:0] rd_data;
   logic [CNT_W+OCC_W-1:0] count_wide;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign is_push = req_action inside {ACT_PUSH_BACK, ACT_PUSH_FRONT};
   assign full   = (count_ff == FULL_COUNT);
   assign empty  = (count_ff == '0);

   // Ring neighbors of the two indices.
   assign head_next = (head_ff == LAST_SLOT) ? '0 : head_ff + IDX_W'(1);
   assign head_prev = (head_ff == '0) ? LAST_SLOT : head_ff - IDX_W'(1);
   assign tail_next = (tail_ff == LAST_SLOT) ? '0 : tail_ff + IDX_W'(1);
   assign tail_prev = (tail_ff == '0) ? LAST_SLOT : tail_ff - IDX_W'(1);

   // Decode the item into index, count and RAM updates.
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      status_in = ST_OK;
      pop_ok_in = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = tail_ff;
      rd_en     = 1'b0;
      rd_addr   = head_ff;
      if (accept) begin
         if (is_push && full) begin
            status_in = ST_OVERFLOW;
         end else if (!is_push && empty) begin
            status_in = ST_UNDERFLOW;
         end else begin
            case (req_action)
               ACT_PUSH_BACK: begin
                  wr_en    = 1'b1;
                  wr_addr  = tail_ff;
                  tail_in  = tail_next;
                  count_in = count_ff + CNT_W'(1);
               end
               ACT_PUSH_FRONT: begin
                  wr_en    = 1'b1;
                  wr_addr  = head_prev;
                  head_in  = head_prev;
                  count_in = count_ff + CNT_W'(1);
               end
               ACT_POP_BACK: begin
                  rd_en     = 1'b1;
                  rd_addr   = tail_prev;
                  tail_in   = tail_prev;
                  count_in  = count_ff - CNT_W'(1);
                  pop_ok_in = 1'b1;
               end
               default: begin
                  rd_en     = 1'b1;
                  rd_addr   = head_ff;
                  head_in   = head_next;
                  count_in  = count_ff - CNT_W'(1);
                  pop_ok_in = 1'b1;
               end
            endcase
         end
      end
   end

   // Control state and the result stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
         pop_ok_ff <= 1'b0;
      end else begin
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         strobe_ff <= accept;
         pop_ok_ff <= pop_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

   // Ring store of the deque words.
   cdq_ram #(
      .WIDTH(WORD_W),
      .DEPTH(CAPACITY)
   ) u_ring (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(req_push_value),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Occupancy is the count masked to the field width.
   assign count_wide = {{OCC_W{1'b0}}, count_ff};

   assign rsp_strobe        = strobe_ff;
   assign rsp_status        = status_ff;
   assign rsp_removed_value = pop_ok_ff ? word_type'(rd_data) : '0;
   assign rsp_occupancy     = count_wide[OCC_W-1:0];

   // Every accepted item yields a result in the next cycle, and nothing else does.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("accepted item produced no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("result without an accepted item");

   // Overflow is reported only with a full deque, underflow only with an empty one.
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_OVERFLOW) |-> (count_ff == FULL_COUNT))
      else $error("overflow reported while not full");

   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_UNDERFLOW) |-> (count_ff == '0))
      else $error("underflow reported while not empty");

   // The count never exceeds the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("stored count above capacity");

endmodule

// ----- hdl/cdq_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
